// ===== sv/lthr_pkg.sv =====
`default_nettype none
// ============================================================================
// lthr_pkg
// shared types, register indexes and constants of the lux threshold reporter
// ============================================================================
package lthr_pkg;

    localparam int TICK_WIDTH_DEFAULT = 32;
    localparam int LUX_W              = 16;
    localparam int VAL_W              = 8;
    localparam int DELAY_W            = 14;
    localparam int CYCLE_W            = 15;
    localparam int CFG_ADDR_W         = 3;
    localparam int CFG_DATA_W         = 16;

    localparam logic [CYCLE_W-1:0] CYCLE_TICKS_RESET = 15'd17490;
    localparam logic [VAL_W-1:0]   DIM_MAX           = 8'd255;
    localparam logic [VAL_W-1:0]   DIM_NEAR_MAX      = 8'd252;
    localparam logic [VAL_W-1:0]   DIM_FINE_STEP     = 8'd4;

    // control_bits fields
    localparam int CTRL_LOCK_BIT        = 3;
    localparam int CTRL_ONCE_ABOVE_BIT  = 4;
    localparam int CTRL_CYCL_ABOVE_BIT  = 5;
    localparam int CTRL_ONCE_BELOW_BIT  = 6;
    localparam int CTRL_CYCL_BELOW_BIT  = 7;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_REGULATE_MODE = 3'd0,
        REG_THRESHOLD_LUX = 3'd1,
        REG_CONTROL_BITS  = 3'd2,
        REG_DELAY_ABOVE   = 3'd3,
        REG_DELAY_BELOW   = 3'd4,
        REG_VALUE_ABOVE   = 3'd5,
        REG_VALUE_BELOW   = 3'd6,
        REG_CYCLE_TICKS   = 3'd7
    } cfg_index_t;

    typedef enum logic {
        OP_EVAL = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        SCHED_OFF     = 2'd0,
        SCHED_CYCLIC  = 2'd1,
        SCHED_ONCE_DL = 2'd2,
        SCHED_CYCL_DL = 2'd3
    } sched_t;

    typedef struct packed {
        logic                regulate_mode;
        logic [LUX_W-1:0]    threshold_lux;
        logic [VAL_W-1:0]    control_bits;
        logic [DELAY_W-1:0]  delay_above;
        logic [DELAY_W-1:0]  delay_below;
        logic [VAL_W-1:0]    value_above;
        logic [VAL_W-1:0]    value_below;
        logic [CYCLE_W-1:0]  cycle_ticks;
        logic [LUX_W-1:0]    low_limit;
    } cfg_t;

    // reciprocal multiplier for threshold / {1,2,10,5,3}, exact over 16 bits
    function automatic logic [LUX_W-1:0] hyst_mul(input logic [2:0] idx);
        logic [LUX_W-1:0] m;
        case (idx)
            3'd2, 3'd3: m = 16'hCCCD;
            3'd4:       m = 16'hAAAB;
            default:    m = 16'h0001;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] hyst_shift(input logic [2:0] idx);
        logic [4:0] s;
        case (idx)
            3'd1:    s = 5'd1;
            3'd2:    s = 5'd19;
            3'd3:    s = 5'd18;
            3'd4:    s = 5'd17;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== sv/lthr_cfg.sv =====
`default_nettype none
// ============================================================================
// lthr_cfg
// configuration registers and the precomputed lower switching limit
// ============================================================================
module lthr_cfg
    import lthr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic [2*LUX_W-1:0] prod;
    logic [2*LUX_W-1:0] quot;
    logic [LUX_W-1:0]   hyst;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                REG_REGULATE_MODE: cfg_next.regulate_mode = cfg_wdata[0];
                REG_THRESHOLD_LUX: cfg_next.threshold_lux = cfg_wdata[LUX_W-1:0];
                REG_CONTROL_BITS:  cfg_next.control_bits  = cfg_wdata[VAL_W-1:0];
                REG_DELAY_ABOVE:   cfg_next.delay_above   = cfg_wdata[DELAY_W-1:0];
                REG_DELAY_BELOW:   cfg_next.delay_below   = cfg_wdata[DELAY_W-1:0];
                REG_VALUE_ABOVE:   cfg_next.value_above   = cfg_wdata[VAL_W-1:0];
                REG_VALUE_BELOW:   cfg_next.value_below   = cfg_wdata[VAL_W-1:0];
                REG_CYCLE_TICKS:   cfg_next.cycle_ticks   = cfg_wdata[CYCLE_W-1:0];
                default: ;
            endcase
        end
        // hysteresis = threshold / divisor, at least 1; low limit saturates at 0
        prod = cfg_next.threshold_lux * hyst_mul(cfg_next.control_bits[2:0]);
        quot = prod >> hyst_shift(cfg_next.control_bits[2:0]);
        hyst = (quot[LUX_W-1:0] == '0) ? LUX_W'(1) : quot[LUX_W-1:0];
        cfg_next.low_limit = (cfg_next.threshold_lux > hyst) ?
                             cfg_next.threshold_lux - hyst : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{regulate_mode: 1'b0,
                         threshold_lux: '0,
                         control_bits:  '0,
                         delay_above:   '0,
                         delay_below:   '0,
                         value_above:   '0,
                         value_below:   '0,
                         cycle_ticks:   CYCLE_TICKS_RESET,
                         low_limit:     '0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== sv/lthr_core.sv =====
`default_nettype none
// ============================================================================
// lthr_core
// input register, channel state, evaluate/tick logic and result register
// ============================================================================
module lthr_core
    import lthr_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cfg_t             cfg,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_opcode,
    input  wire logic [LUX_W-1:0] s_lux_sample,
    input  wire logic             s_lock_input,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_send_strobe,
    output logic [VAL_W-1:0]      m_sent_value,
    output logic [VAL_W-1:0]      m_object_value,
    output logic [VAL_W-1:0]      m_dim_level_out,
    output logic                  m_above_flag,
    output logic                  m_below_flag
);

    // input stage
    logic             in_valid_reg;
    opcode_t          in_opcode_reg;
    logic [LUX_W-1:0] in_lux_reg;
    logic             in_lock_reg;

    // channel state
    logic [TICK_WIDTH-1:0] tick_count_reg, tick_count_next;
    sched_t                sched_reg, sched_next;
    logic [TICK_WIDTH-1:0] due_time_reg, due_time_next;
    logic                  above_sent_reg, above_sent_next;
    logic                  below_sent_reg, below_sent_next;
    logic [VAL_W-1:0]      dim_level_reg, dim_level_next;
    logic [VAL_W-1:0]      stored_object_reg, stored_object_next;

    // result stage
    logic             m_valid_reg;
    logic             strobe_reg, strobe_next;
    logic [VAL_W-1:0] sent_value_reg, sent_value_next;

    logic             advance;
    logic             blocked;
    logic             is_above;
    logic             is_below;
    logic [3:0]       nib;
    logic [VAL_W-1:0] step;
    logic [TICK_WIDTH-1:0] tick_inc;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        tick_count_next    = tick_count_reg;
        sched_next         = sched_reg;
        due_time_next      = due_time_reg;
        above_sent_next    = above_sent_reg;
        below_sent_next    = below_sent_reg;
        dim_level_next     = dim_level_reg;
        stored_object_next = stored_object_reg;
        strobe_next        = 1'b0;
        sent_value_next    = '0;

        tick_inc = tick_count_reg + TICK_WIDTH'(1);
        blocked  = cfg.control_bits[CTRL_LOCK_BIT] && in_lock_reg;
        is_above = in_lux_reg > cfg.threshold_lux;
        is_below = in_lux_reg < cfg.low_limit;
        nib      = cfg.control_bits[7:4];
        step     = {((nib == 4'hF) ? 4'hF : nib + 4'd1), 4'd0};

        case (in_opcode_reg)
            OP_TICK: begin
                tick_count_next = tick_inc;
                if (sched_reg != SCHED_OFF && due_time_reg == tick_inc) begin
                    strobe_next = 1'b1;
                    if (cfg.regulate_mode) begin
                        sent_value_next = dim_level_reg;
                    end else if (above_sent_reg) begin
                        sent_value_next = cfg.value_above;
                    end else begin
                        sent_value_next = cfg.value_below;
                    end
                    if (sched_reg[0]) begin
                        sched_next    = SCHED_CYCLIC;
                        due_time_next = tick_inc + TICK_WIDTH'(cfg.cycle_ticks);
                    end else begin
                        sched_next    = SCHED_OFF;
                        due_time_next = '0;
                    end
                end
            end
            OP_EVAL: begin
                if (cfg.regulate_mode) begin
                    if (!blocked) begin
                        if (is_above) begin
                            if ({1'b0, in_lux_reg} > {cfg.threshold_lux, 1'b0} &&
                                dim_level_reg >= step) begin
                                dim_level_next = dim_level_reg - step;
                            end else begin
                                dim_level_next = (dim_level_reg > 8'd3) ?
                                                 dim_level_reg - DIM_FINE_STEP : '0;
                            end
                        end
                        if (is_below) begin
                            if ({in_lux_reg, 1'b0} < {1'b0, cfg.low_limit} &&
                                dim_level_reg <= DIM_MAX - step) begin
                                dim_level_next = dim_level_reg + step;
                            end else begin
                                dim_level_next = (dim_level_reg < DIM_NEAR_MAX) ?
                                                 dim_level_reg + DIM_FINE_STEP : DIM_MAX;
                            end
                        end
                        if (dim_level_next != dim_level_reg) begin
                            strobe_next     = 1'b1;
                            sent_value_next = dim_level_next;
                            sched_next      = SCHED_CYCLIC;
                            due_time_next   = tick_count_reg + TICK_WIDTH'(cfg.cycle_ticks);
                        end
                    end
                end else if (blocked) begin
                    sched_next      = SCHED_OFF;
                    due_time_next   = '0;
                    above_sent_next = 1'b0;
                    below_sent_next = 1'b0;
                end else begin
                    if (is_above) begin
                        if ((cfg.control_bits[CTRL_ONCE_ABOVE_BIT] ||
                             cfg.control_bits[CTRL_CYCL_ABOVE_BIT]) && !above_sent_reg) begin
                            if (cfg.delay_above != '0) begin
                                sched_next = sched_t'({1'b1,
                                             cfg.control_bits[CTRL_CYCL_ABOVE_BIT]});
                                due_time_next = tick_count_reg +
                                                TICK_WIDTH'(cfg.delay_above);
                            end else begin
                                sched_next = sched_t'({1'b0,
                                             cfg.control_bits[CTRL_CYCL_ABOVE_BIT]});
                                due_time_next = tick_count_reg +
                                                TICK_WIDTH'(cfg.cycle_ticks);
                                strobe_next     = 1'b1;
                                sent_value_next = cfg.value_above;
                            end
                            stored_object_next = cfg.value_above;
                            above_sent_next    = 1'b1;
                        end
                        below_sent_next = 1'b0;
                    end
                    if (is_below) begin
                        if ((cfg.control_bits[CTRL_ONCE_BELOW_BIT] ||
                             cfg.control_bits[CTRL_CYCL_BELOW_BIT]) && !below_sent_reg) begin
                            if (cfg.delay_below != '0) begin
                                sched_next = sched_t'({1'b1,
                                             cfg.control_bits[CTRL_CYCL_BELOW_BIT]});
                                due_time_next = tick_count_reg +
                                                TICK_WIDTH'(cfg.delay_below);
                            end else begin
                                sched_next = sched_t'({1'b0,
                                             cfg.control_bits[CTRL_CYCL_BELOW_BIT]});
                                due_time_next = tick_count_reg +
                                                TICK_WIDTH'(cfg.cycle_ticks);
                                strobe_next     = 1'b1;
                                sent_value_next = cfg.value_below;
                            end
                            stored_object_next = cfg.value_below;
                            below_sent_next    = 1'b1;
                        end
                        above_sent_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg <= opcode_t'(s_opcode);
            in_lux_reg    <= s_lux_sample;
            in_lock_reg   <= s_lock_input;
        end
    end

    // channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg    <= '0;
            sched_reg         <= SCHED_OFF;
            due_time_reg      <= '0;
            above_sent_reg    <= 1'b0;
            below_sent_reg    <= 1'b0;
            dim_level_reg     <= '0;
            stored_object_reg <= '0;
        end else if (advance) begin
            tick_count_reg    <= tick_count_next;
            sched_reg         <= sched_next;
            due_time_reg      <= due_time_next;
            above_sent_reg    <= above_sent_next;
            below_sent_reg    <= below_sent_next;
            dim_level_reg     <= dim_level_next;
            stored_object_reg <= stored_object_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            strobe_reg     <= strobe_next;
            sent_value_reg <= sent_value_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_send_strobe   = strobe_reg;
    assign m_sent_value    = sent_value_reg;
    assign m_object_value  = stored_object_reg;
    assign m_dim_level_out = dim_level_reg;
    assign m_above_flag    = above_sent_reg;
    assign m_below_flag    = below_sent_reg;

`ifndef NO_ASSERTIONS
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(above_sent_reg && below_sent_reg))
        else $error("above and below flags both set");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(strobe_reg) &&
                                       $stable(sent_value_reg) &&
                                       $stable(stored_object_reg)))
        else $error("stalled result transaction changed");

    a_quiet_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !strobe_reg) |-> (sent_value_reg == '0))
        else $error("value reported without strobe");

    a_advance_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("processed transaction did not reach result register");
`endif

endmodule
`default_nettype wire

// ===== sv/lux_threshold_hysteresis_reporter_unit.sv =====
`default_nettype none
// ============================================================================
// lux_threshold_hysteresis_reporter_unit
// brightness threshold switch with hysteresis, delayed and cyclic reports,
// and dim-level regulation mode
// ============================================================================
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  input    | s_valid / s_ready   | s_opcode, s_lux_sample, s_lock_input
//  result   | m_valid / m_ready   | m_send_strobe, m_sent_value, m_object_value,
//           |                     | m_dim_level_out, m_above_flag, m_below_flag
//  config   | cfg_we              | cfg_addr, cfg_wdata
//
//  one transaction per cycle unless the result stalls; input and result registered
//  the input register feeds one evaluate/tick step that updates state and the
//  result register in the same edge; the low limit is computed on config write
//  aresetn clears state, flags and config to defaults (cycle_ticks 17490)
//  a stalled result holds the input register; s_ready follows m_ready when full
//
module lux_threshold_hysteresis_reporter_unit
    import lthr_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_opcode,
    input  wire logic [LUX_W-1:0]      s_lux_sample,
    input  wire logic                  s_lock_input,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_send_strobe,
    output logic [VAL_W-1:0]           m_sent_value,
    output logic [VAL_W-1:0]           m_object_value,
    output logic [VAL_W-1:0]           m_dim_level_out,
    output logic                       m_above_flag,
    output logic                       m_below_flag
);

    cfg_t cfg;

    lthr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lthr_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_lux_sample    (s_lux_sample),
        .s_lock_input    (s_lock_input),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_send_strobe   (m_send_strobe),
        .m_sent_value    (m_sent_value),
        .m_object_value  (m_object_value),
        .m_dim_level_out (m_dim_level_out),
        .m_above_flag    (m_above_flag),
        .m_below_flag    (m_below_flag)
    );

endmodule
`default_nettype wire

// ===== verif/lux_report_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lux_report_checker
// follows the register writes and both channels of the lux threshold
// reporter, computes the report due for every input transaction and compares
// it with the result transactions in order, counting every mismatch
// ============================================================================
module lux_report_checker
    import lthr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic                  s_opcode,
    input  wire logic [LUX_W-1:0]      s_lux_sample,
    input  wire logic                  s_lock_input,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic                  m_send_strobe,
    input  wire logic [VAL_W-1:0]      m_sent_value,
    input  wire logic [VAL_W-1:0]      m_object_value,
    input  wire logic [VAL_W-1:0]      m_dim_level_out,
    input  wire logic                  m_above_flag,
    input  wire logic                  m_below_flag,
    output int unsigned                fail_count,
    output int unsigned                pending
);

    localparam int TW         = TICK_WIDTH_DEFAULT;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic             send_strobe;
        logic [VAL_W-1:0] sent_value;
        logic [VAL_W-1:0] object_value;
        logic [VAL_W-1:0] dim_level;
        logic             above_flag;
        logic             below_flag;
    } lux_report_t;

    // register copies
    logic               regulate_on;
    logic [LUX_W-1:0]   thr_lux;
    logic [VAL_W-1:0]   ctrl;
    logic [DELAY_W-1:0] dly_above;
    logic [DELAY_W-1:0] dly_below;
    logic [VAL_W-1:0]   val_above;
    logic [VAL_W-1:0]   val_below;
    logic [CYCLE_W-1:0] period;

    // channel state
    logic [TW-1:0]    ticks;
    logic [TW-1:0]    due;
    sched_t           sched;
    logic             above_done;
    logic             below_done;
    logic [VAL_W-1:0] dim;
    logic [VAL_W-1:0] obj;

    lux_report_t expected_reports[$];
    int unsigned errors;

    function automatic void arm(input logic [1:0] mode, input logic [TW-1:0] when);
        sched = sched_t'(mode);
        due   = when;
    endfunction

    function automatic lux_report_t next_report(input opcode_t op,
                                                input logic [LUX_W-1:0] lux,
                                                input logic lock);
        lux_report_t      r;
        int unsigned      div;
        int unsigned      thr;
        int unsigned      hyst;
        int unsigned      low;
        int unsigned      step;
        logic [VAL_W-1:0] prev;
        logic             blocked;
        r = '0;
        if (op == OP_TICK) begin
            ticks = ticks + 1'b1;
            if (sched != SCHED_OFF && due == ticks) begin
                r.send_strobe = 1'b1;
                if (regulate_on) begin
                    r.sent_value = dim;
                end else begin
                    r.sent_value = above_done ? val_above : val_below;
                end
                if (sched[0]) begin
                    arm(SCHED_CYCLIC, ticks + period);
                end else begin
                    arm(SCHED_OFF, '0);
                end
            end
        end else begin
            case (ctrl[2:0])
                3'd1:    div = 2;
                3'd2:    div = 10;
                3'd3:    div = 5;
                3'd4:    div = 3;
                default: div = 1;
            endcase
            thr  = thr_lux;
            hyst = thr / div;
            if (hyst == 0) hyst = 1;
            low     = (thr > hyst) ? thr - hyst : 0;
            blocked = ctrl[CTRL_LOCK_BIT] && lock;
            if (regulate_on) begin
                step = (ctrl[7:4] == 4'hF) ? 240 : (int'(ctrl[7:4]) + 1) * 16;
                prev = dim;
                if (!blocked) begin
                    if (lux > thr) begin
                        if (lux > 2 * thr && dim >= step) dim = dim - step;
                        else dim = (dim > 3) ? dim - 4 : 0;
                    end
                    if (lux < low) begin
                        if (2 * lux < low && dim <= 255 - step) dim = dim + step;
                        else dim = (dim < 252) ? dim + 4 : 255;
                    end
                    if (dim != prev) begin
                        r.send_strobe = 1'b1;
                        r.sent_value  = dim;
                        arm(SCHED_CYCLIC, ticks + period);
                    end
                end
            end else if (blocked) begin
                arm(SCHED_OFF, '0);
                above_done = 1'b0;
                below_done = 1'b0;
            end else begin
                if (lux > thr) begin
                    if ((ctrl[CTRL_ONCE_ABOVE_BIT] || ctrl[CTRL_CYCL_ABOVE_BIT]) && !above_done) begin
                        if (dly_above != 0) begin
                            arm({1'b1, ctrl[CTRL_CYCL_ABOVE_BIT]}, ticks + dly_above);
                        end else begin
                            arm({1'b0, ctrl[CTRL_CYCL_ABOVE_BIT]}, ticks + period);
                            r.send_strobe = 1'b1;
                            r.sent_value  = val_above;
                        end
                        obj        = val_above;
                        above_done = 1'b1;
                    end
                    below_done = 1'b0;
                end
                if (lux < low) begin
                    if ((ctrl[CTRL_ONCE_BELOW_BIT] || ctrl[CTRL_CYCL_BELOW_BIT]) && !below_done) begin
                        if (dly_below != 0) begin
                            arm({1'b1, ctrl[CTRL_CYCL_BELOW_BIT]}, ticks + dly_below);
                        end else begin
                            arm({1'b0, ctrl[CTRL_CYCL_BELOW_BIT]}, ticks + period);
                            r.send_strobe = 1'b1;
                            r.sent_value  = val_below;
                        end
                        obj        = val_below;
                        below_done = 1'b1;
                    end
                    above_done = 1'b0;
                end
            end
        end
        r.object_value = obj;
        r.dim_level    = dim;
        r.above_flag   = above_done;
        r.below_flag   = below_done;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        lux_report_t want;
        lux_report_t got;
        if (!aresetn) begin
            regulate_on = 1'b0;
            thr_lux     = '0;
            ctrl        = '0;
            dly_above   = '0;
            dly_below   = '0;
            val_above   = '0;
            val_below   = '0;
            period      = CYCLE_TICKS_RESET;
            ticks       = '0;
            due         = '0;
            sched       = SCHED_OFF;
            above_done  = 1'b0;
            below_done  = 1'b0;
            dim         = '0;
            obj         = '0;
            errors      = 0;
            expected_reports.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_addr))
                    REG_REGULATE_MODE: regulate_on = cfg_wdata[0];
                    REG_THRESHOLD_LUX: thr_lux     = cfg_wdata[LUX_W-1:0];
                    REG_CONTROL_BITS:  ctrl        = cfg_wdata[VAL_W-1:0];
                    REG_DELAY_ABOVE:   dly_above   = cfg_wdata[DELAY_W-1:0];
                    REG_DELAY_BELOW:   dly_below   = cfg_wdata[DELAY_W-1:0];
                    REG_VALUE_ABOVE:   val_above   = cfg_wdata[VAL_W-1:0];
                    REG_VALUE_BELOW:   val_below   = cfg_wdata[VAL_W-1:0];
                    REG_CYCLE_TICKS:   period      = cfg_wdata[CYCLE_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = {m_send_strobe, m_sent_value, m_object_value, m_dim_level_out,
                       m_above_flag, m_below_flag};
                if (expected_reports.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX) begin
                        $display("%0t: result transaction with none expected: %p", $realtime, got);
                    end
                end else begin
                    want = expected_reports.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= REPORT_MAX) begin
                            $display("%0t: mismatch exp/act strobe %0b/%0b value %0d/%0d",
                                     $realtime, want.send_strobe, got.send_strobe,
                                     want.sent_value, got.sent_value);
                            $display("    object %0d/%0d dim %0d/%0d above %0b/%0b below %0b/%0b",
                                     want.object_value, got.object_value,
                                     want.dim_level, got.dim_level,
                                     want.above_flag, got.above_flag,
                                     want.below_flag, got.below_flag);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_reports.push_back(next_report(opcode_t'(s_opcode), s_lux_sample,
                                                       s_lock_input));
            end
        end
        fail_count <= errors;
        pending    <= expected_reports.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// drives the lux threshold reporter through directed corner cases and
// random register settings in both modes under varying idle patterns
// ============================================================================
module testbench;
    import lthr_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int ITEMS_PER_SETTING = 70;

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_opcode     = 1'b0;
    logic [LUX_W-1:0]      s_lux_sample = '0;
    logic                  s_lock_input = 1'b0;
    logic                  m_ready      = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_send_strobe;
    logic [VAL_W-1:0]      m_sent_value;
    logic [VAL_W-1:0]      m_object_value;
    logic [VAL_W-1:0]      m_dim_level_out;
    logic                  m_above_flag;
    logic                  m_below_flag;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 56;
    int unsigned items_taken   = 0;
    int unsigned results_taken = 0;
    int unsigned stall_cycles  = 0;
    int unsigned settings_used = 0;
    int unsigned cur_thr       = 0;

    lux_threshold_hysteresis_reporter_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_lux_sample    (s_lux_sample),
        .s_lock_input    (s_lock_input),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_send_strobe   (m_send_strobe),
        .m_sent_value    (m_sent_value),
        .m_object_value  (m_object_value),
        .m_dim_level_out (m_dim_level_out),
        .m_above_flag    (m_above_flag),
        .m_below_flag    (m_below_flag)
    );

    lux_report_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_lux_sample    (s_lux_sample),
        .s_lock_input    (s_lock_input),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_send_strobe   (m_send_strobe),
        .m_sent_value    (m_sent_value),
        .m_object_value  (m_object_value),
        .m_dim_level_out (m_dim_level_out),
        .m_above_flag    (m_above_flag),
        .m_below_flag    (m_below_flag),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (s_valid && s_ready) items_taken++;
        if (m_valid && m_ready) results_taken++;
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     stall_cycles, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(input opcode_t op, input logic [LUX_W-1:0] lux, input logic lock);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_lux_sample <= lux;
        s_lock_input <= lock;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold the input side until every outstanding result has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic configure(input logic mode, input logic [LUX_W-1:0] thr,
                             input logic [VAL_W-1:0] ctrl,
                             input logic [DELAY_W-1:0] dly_above,
                             input logic [DELAY_W-1:0] dly_below,
                             input logic [VAL_W-1:0] val_above,
                             input logic [VAL_W-1:0] val_below,
                             input logic [CYCLE_W-1:0] period);
        drain();
        repeat (4) @(posedge aclk);
        write_reg(REG_REGULATE_MODE, CFG_DATA_W'(mode));
        write_reg(REG_THRESHOLD_LUX, CFG_DATA_W'(thr));
        write_reg(REG_CONTROL_BITS,  CFG_DATA_W'(ctrl));
        write_reg(REG_DELAY_ABOVE,   CFG_DATA_W'(dly_above));
        write_reg(REG_DELAY_BELOW,   CFG_DATA_W'(dly_below));
        write_reg(REG_VALUE_ABOVE,   CFG_DATA_W'(val_above));
        write_reg(REG_VALUE_BELOW,   CFG_DATA_W'(val_below));
        write_reg(REG_CYCLE_TICKS,   CFG_DATA_W'(period));
        cfg_we  <= 1'b0;
        cur_thr = thr;
        settings_used++;
    endtask

    function automatic logic [DELAY_W-1:0] pick_delay();
        if ($urandom_range(2) == 0) return '0;
        if ($urandom_range(19) == 0) return DELAY_W'($urandom_range(8745));
        return DELAY_W'($urandom_range(1, 6));
    endfunction

    task automatic random_setting();
        logic [LUX_W-1:0]   thr;
        logic [CYCLE_W-1:0] period;
        case ($urandom_range(7))
            0:       thr = '0;
            1:       thr = 16'hFFFF;
            5, 6:    thr = LUX_W'($urandom_range(65535));
            7:       thr = LUX_W'($urandom_range(1, 20));
            default: thr = LUX_W'($urandom_range(50, 3000));
        endcase
        case ($urandom_range(19))
            0:       period = '0;
            1:       period = CYCLE_TICKS_RESET;
            2:       period = CYCLE_W'($urandom_range(1, 17490));
            default: period = CYCLE_W'($urandom_range(1, 8));
        endcase
        configure($urandom_range(2) == 0, thr, VAL_W'($urandom_range(255)),
                  pick_delay(), pick_delay(), VAL_W'($urandom_range(255)),
                  VAL_W'($urandom_range(255)), period);
    endtask

    // samples near the threshold, hysteresis band and twice it; low, extreme or any
    task automatic random_item();
        int      v;
        int      t;
        opcode_t op;
        t  = cur_thr;
        op = ($urandom_range(99) < 40) ? OP_TICK : OP_EVAL;
        case ($urandom_range(5))
            0:       v = $urandom_range(65535);
            1:       v = $urandom_range(t / 2);
            2:       v = t - t / int'($urandom_range(1, 12)) + int'($urandom_range(4)) - 2;
            3:       v = t + int'($urandom_range(t / 2 + 3));
            4:       v = 2 * t + int'($urandom_range(200)) - 100;
            default: v = $urandom_range(1) ? 65535 : 0;
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        send_item(op, LUX_W'(v), $urandom_range(9) == 0);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero threshold: low limit saturates at zero, cyclic resend, lock clear
        configure(1'b0, 16'd0, 8'hFC, 14'd0, 14'd0, 8'hFF, 8'h00, 15'd3);
        send_item(OP_EVAL, 16'hFFFF, 1'b0);
        repeat (3) send_item(OP_TICK, 16'h0000, 1'b0);
        send_item(OP_EVAL, 16'h0000, 1'b0);
        send_item(OP_EVAL, 16'hFFFF, 1'b1);
        repeat (3) send_item(OP_TICK, 16'hFFFF, 1'b1);
        send_item(OP_EVAL, 16'hFFFF, 1'b0);

        // top threshold, delayed report below, lock not honored, longest delay and period
        configure(1'b0, 16'hFFFF, 8'hD2, 14'd8745, 14'd1, 8'h5A, 8'hA5, CYCLE_TICKS_RESET);
        send_item(OP_EVAL, 16'h0000, 1'b1);
        send_item(OP_TICK, 16'h0000, 1'b0);
        send_item(OP_EVAL, 16'hFFFF, 1'b0);

        // regulation with step nibble 15, coarse and fine steps, lock, resend
        configure(1'b1, 16'd1000, 8'hF9, 14'd0, 14'd0, 8'h00, 8'h00, 15'd2);
        send_item(OP_EVAL, 16'd100, 1'b0);
        send_item(OP_EVAL, 16'd100, 1'b0);
        send_item(OP_EVAL, 16'd3000, 1'b0);
        send_item(OP_EVAL, 16'd1500, 1'b0);
        send_item(OP_EVAL, 16'd1500, 1'b0);
        send_item(OP_EVAL, 16'd100, 1'b1);
        repeat (2) send_item(OP_TICK, 16'd0, 1'b0);
        send_item(OP_EVAL, 16'd700, 1'b0);

        // zero cycle period
        configure(1'b0, 16'd200, 8'hA1, 14'd0, 14'd0, 8'h11, 8'h22, 15'd0);
        send_item(OP_EVAL, 16'd50, 1'b0);
        send_item(OP_TICK, 16'd0, 1'b0);
        send_item(OP_EVAL, 16'd300, 1'b0);
        send_item(OP_TICK, 16'd0, 1'b0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct <= 35;
                    recv_idle_pct <= 56;
                end
                1: begin
                    send_idle_pct <= 56;
                    recv_idle_pct <= 35;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (int k = 0; k < 3; k++) begin
                random_setting();
                for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                    if (n == 30 || $urandom_range(79) == 0) drain();
                    random_item();
                end
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        $display("run covered %0d input and %0d result transactions over %0d register settings,",
                 items_taken, results_taken, settings_used);
        $display("both modes, lock, delayed and cyclic reports, under three idle patterns");
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results still outstanding", fail_count, pending);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
